[hw/rtl/sysex_fragment_deframer_core_macros.svh]
// Assertion macros for the fragment deframer.
`ifndef SYSEX_FRAGMENT_DEFRAMER_CORE_MACROS_SVH
`define SYSEX_FRAGMENT_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define SFD_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SFD_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sfd_pkg.sv]
// Types and constants shared by the fragment deframer modules.
package sfd_pkg;

	localparam logic [7:0] TAIL_BYTE    = 8'hF7;
	localparam int         RESULT_LIMIT = 59;
	localparam int         CNT_W        = 6;

	typedef struct packed {
		logic [7:0] midi_byte;
		logic       end_of_fragment;
	} frag_beat_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       starts_message;
		logic       message_complete;
		logic       last;
	} res_beat_t;

	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] count;
		logic             starts;
		logic             final_frag;
	} frag_done_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} emit_state_t;

	function automatic logic [7:0] header_byte(input logic [2:0] pos);
		logic [7:0] v;
		unique case (pos)
			3'd0:    v = 8'hF0;
			3'd1:    v = 8'h7D;
			3'd2:    v = 8'h01;
			3'd3:    v = 8'h03;
			3'd4:    v = 8'h03;
			3'd5:    v = 8'h07;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/sfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/sfd_parse.sv]
// Per-beat fragment parser: header check, nibble join, length and tail check.
module sfd_parse import sfd_pkg::*; #(
	parameter int MAX_FRAGMENT_BYTES = 128,
	parameter int BUFFER_DEPTH       = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  frag_beat_t                      frag,
	output logic                            wr_en,
	output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
	output logic [7:0]                      wr_data,
	output frag_done_t                      done
);

	logic [7:0] pos_q;
	logic       ovl_q;
	logic       hdr_good_q;
	logic [7:0] dlen_q;
	logic [7:0] rem_q;
	logic [3:0] hnib_q;
	logic [7:0] exp_q;
	logic       pend_q;

	logic [7:0] b;
	logic [7:0] off;
	logic [6:0] idx;
	logic [8:0] len;
	logic [9:0] want_len;
	logic       ovl_now;
	logic       in_data;
	logic       valid;
	logic       starts;

	always_comb begin
		b        = frag.midi_byte;
		off      = pos_q - 8'd8;
		idx      = off[7:1];
		in_data  = (pos_q >= 8'd8);
		ovl_now  = ovl_q || (pos_q >= 8'(MAX_FRAGMENT_BYTES));
		len      = {1'b0, pos_q} + 9'd1;
		want_len = {1'b0, dlen_q, 1'b0} + 10'd9;
		valid    = !ovl_now && hdr_good_q && (len >= 9'd9) && ({1'b0, len} == want_len)
			&& (len <= 9'(MAX_FRAGMENT_BYTES)) && (b == TAIL_BYTE) && (dlen_q != 8'd0)
			&& ({1'b0, dlen_q} <= 9'(BUFFER_DEPTH)) && (dlen_q <= 8'(RESULT_LIMIT));
		starts   = !(pend_q && ({1'b0, exp_q} == ({1'b0, rem_q} + 9'd1)));

		wr_en    = accept && in_data && off[0] && ({1'b0, idx} < 8'(BUFFER_DEPTH));
		wr_addr  = $clog2(BUFFER_DEPTH)'(idx);
		wr_data  = {hnib_q, b[3:0]};

		done.go         = accept && frag.end_of_fragment && valid;
		done.count      = dlen_q[CNT_W-1:0];
		done.starts     = starts;
		done.final_frag = (rem_q == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ovl_q      <= 1'b0;
			hdr_good_q <= 1'b1;
			dlen_q     <= '0;
			rem_q      <= '0;
			hnib_q     <= '0;
			exp_q      <= 8'd1;
			pend_q     <= 1'b0;
		end else if (accept) begin
			if (frag.end_of_fragment) begin
				pos_q      <= '0;
				ovl_q      <= 1'b0;
				hdr_good_q <= 1'b1;
				dlen_q     <= '0;
				rem_q      <= '0;
				hnib_q     <= '0;
				if (valid) begin
					exp_q  <= rem_q;
					pend_q <= (rem_q != 8'd0);
				end
			end else begin
				if (ovl_now) begin
					ovl_q <= 1'b1;
				end
				if (pos_q < 8'd6) begin
					if (b != header_byte(pos_q[2:0])) begin
						hdr_good_q <= 1'b0;
					end
				end else if (pos_q == 8'd6) begin
					dlen_q <= b;
				end else if (pos_q == 8'd7) begin
					rem_q <= b;
				end else if (!off[0]) begin
					hnib_q <= b[3:0];
				end
				if (pos_q != 8'd255) begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

endmodule

[hw/rtl/sfd_emit.sv]
// Result sequencer: walks the buffer through the RAM read port, one byte per beat.
module sfd_emit import sfd_pkg::*; #(
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frag_done_t        done,
	input  logic [7:0]        rd_data,
	input  logic              res_stall,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	output logic              busy,
	output logic              res_valid,
	output res_beat_t         res
);

	emit_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] count_q;
	logic             starts_q;
	logic             final_q;
	logic             is_last;

	always_comb begin
		is_last              = (cnt_q == count_q - CNT_W'(1));
		rd_en                = (state_q == ST_READ);
		rd_addr              = ADDR_W'(cnt_q);
		busy                 = (state_q != ST_IDLE);
		res_valid            = (state_q == ST_SHOW);
		res.data_byte        = rd_data;
		res.starts_message   = starts_q;
		res.message_complete = is_last && final_q;
		res.last             = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			count_q  <= '0;
			starts_q <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (done.go) begin
						count_q  <= done.count;
						starts_q <= done.starts;
						final_q  <= done.final_frag;
						cnt_q    <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (!res_stall) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/sysex_fragment_deframer_core.sv]
// Top level of the MIDI system exclusive fragment deframer.
//
// Usage:
//  frag channel: one raw fragment byte per beat, end_of_fragment on the last.
//  res channel: decoded data bytes of each valid, non-empty fragment.
//  While idle, frag_stall is low and a byte is taken every cycle. On the
//  last byte of a valid fragment the parser hands the data length to the
//  emitter and frag_stall rises for the whole emission.
//  Each result uses the single buffer read port in ST_READ, then shows
//  in ST_SHOW, so a fragment of L data bytes (L at most 59) holds the
//  input off for all its results plus any res_stall time; the first
//  result shows after ST_READ once the final fragment byte is taken.
//  Invalid or empty fragments produce no beats and leave the message state
//  untouched.
//  A result beat holds steady while res_stall is high; the next read starts
//  only after it is taken.
//  Reset clears the parser and sequencer at once; the buffer needs no clear,
//  as only entries written by the current fragment are read.
module sysex_fragment_deframer_core import sfd_pkg::*; #(
	parameter int MAX_FRAGMENT_BYTES = 128,
	parameter int BUFFER_DEPTH       = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       frag_valid,
	output logic       frag_stall,
	input  frag_beat_t frag,
	output logic       res_valid,
	input  logic       res_stall,
	output res_beat_t  res
);

	`include "sysex_fragment_deframer_core_macros.svh"

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic          frag_accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          busy;
	frag_done_t    done;

	assign frag_accept = frag_valid && !frag_stall;
	assign frag_stall  = busy;

	sfd_parse #(
		.MAX_FRAGMENT_BYTES(MAX_FRAGMENT_BYTES),
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.accept(frag_accept),
		.frag(frag),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.done(done)
	);

	sfd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	sfd_emit #(
		.ADDR_W(AW)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.done(done),
		.rd_data(rd_data),
		.res_stall(res_stall),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.busy(busy),
		.res_valid(res_valid),
		.res(res)
	);

	`SFD_CHK_NOW(a_stall_while_emit, res_valid, frag_stall, "input taken during emission")
	`SFD_CHK_NOW(a_complete_on_last, res_valid && res.message_complete, res.last,
		"message_complete without last")
	`SFD_CHK_NEXT(a_gap_after_beat, res_valid && !res_stall && !res.last,
		!res_valid && frag_stall, "emission broke off or repeated a beat")
	`SFD_CHK_NEXT(a_go_starts_emit, frag_accept && done.go, frag_stall && !res_valid,
		"valid fragment end did not start emission")

endmodule
